>>> sv/sase_pkg.sv
package sase_pkg;

   // Default geometry of the key store
   localparam int DEPTH_DEFAULT     = 16;
   localparam int KEY_WIDTH_DEFAULT = 32;

   // Fixed port field widths
   localparam int MODE_W   = 2;
   localparam int KEY_IN_W = 32;
   localparam int POS_W    = 5;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 5;

   // Request modes
   localparam logic [MODE_W-1:0] MODE_INSERT    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DEL_VALUE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DEL_POS   = 2'd2;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_DONE    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_DUP     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_MISSING = 3'd3;
   localparam logic [STATUS_W-1:0] ST_BADPOS  = 3'd4;

   // Outcome of the shared key comparator
   typedef struct packed {
      logic less;
      logic equal;
   } cmp_result_type;

endpackage

>>> sv/sase_ram.sv
module sase_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

>>> sv/sase_cmp.sv
module sase_cmp
   import sase_pkg::*;
#(
   parameter int KEY_WIDTH = KEY_WIDTH_DEFAULT
) (
   input  logic                 compare_signed,
   input  logic [KEY_WIDTH-1:0] stored_key,
   input  logic [KEY_WIDTH-1:0] probe_key,
   output cmp_result_type       result
);

   logic [KEY_WIDTH-1:0] flip;
   logic [KEY_WIDTH-1:0] stored_ord;
   logic [KEY_WIDTH-1:0] probe_ord;

   // Flipping the sign bit maps two's complement order onto unsigned order
   assign flip       = KEY_WIDTH'(compare_signed) << (KEY_WIDTH - 1);
   assign stored_ord = stored_key ^ flip;
   assign probe_ord  = probe_key ^ flip;

   assign result.less  = stored_ord < probe_ord;
   assign result.equal = stored_key == probe_key;

endmodule

>>> sv/sorted_array_set_engine.sv
// Sorted key set, one request at a time; busy, once raised, falls with the result strobe.
// A bad position or unknown mode is answered from idle without raising busy; else each
//   entry compared or moved takes a read state and a compare or write state, as the one
//   memory read port and the shared comparator allow. Start is taken only in idle.
// The result strobe lasts one cycle and the receiver cannot stall it.
// Reset empties the store (count to zero, memory left as is) and selects unsigned order.
module sorted_array_set_engine
   import sase_pkg::*;
#(
   parameter int DEPTH     = DEPTH_DEFAULT,
   parameter int KEY_WIDTH = KEY_WIDTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [MODE_W-1:0]   req_mode,
   input  logic [KEY_IN_W-1:0] req_key_value,
   input  logic [POS_W-1:0]    req_position,
   output logic                rsp_strobe,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [COUNT_W-1:0]  rsp_entry_count,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic                csr_compare_signed
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_UP_RD,
      S_UP_WR,
      S_DOWN_RD,
      S_DOWN_WR
   } state_type;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      ptr_ff, ptr_in;
   logic [CNT_W-1:0]      ins_pos_ff, ins_pos_in;
   logic [MODE_W-1:0]     mode_ff, mode_in;
   logic [KEY_WIDTH-1:0]  key_ff, key_in;
   logic                  signed_ff;
   logic                  strobe_ff, strobe_in;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic [COUNT_W-1:0]    rsp_count_ff, rsp_count_in;

   logic                  wr_en;
   logic [CNT_W-1:0]      wr_ptr;
   logic [KEY_WIDTH-1:0]  wr_data;
   logic [CNT_W-1:0]      rd_ptr;
   logic [KEY_WIDTH-1:0]  rd_data;
   cmp_result_type        cmp;

   // Key memory
   sase_ram #(
      .WIDTH (KEY_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_ptr[IDX_W-1:0]),
      .wr_data (wr_data),
      .rd_addr (rd_ptr[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   // Shared comparator: stored entry against the request key
   sase_cmp #(
      .KEY_WIDTH (KEY_WIDTH)
   ) u_cmp (
      .compare_signed (signed_ff),
      .stored_key     (rd_data),
      .probe_key      (key_ff),
      .result         (cmp)
   );

   // Memory addressing per state
   always_comb begin
      rd_ptr  = '0;
      wr_en   = 1'b0;
      wr_ptr  = ptr_ff;
      wr_data = rd_data;
      case (state_ff)
         S_SCAN_RD: rd_ptr = ptr_ff;
         S_UP_RD: begin
            rd_ptr = ptr_ff - 1'b1;
            if (ptr_ff == ins_pos_ff) begin
               wr_en   = 1'b1;
               wr_data = key_ff;
            end
         end
         S_UP_WR:   wr_en  = 1'b1;
         S_DOWN_RD: rd_ptr = ptr_ff + 1'b1;
         S_DOWN_WR: wr_en  = 1'b1;
         default:   rd_ptr = '0;
      endcase
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      ins_pos_in   = ins_pos_ff;
      mode_in      = mode_ff;
      key_in       = key_ff;
      strobe_in    = 1'b0;
      status_in    = status_ff;
      rsp_count_in = rsp_count_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               mode_in = req_mode;
               key_in  = KEY_WIDTH'(req_key_value);
               ptr_in  = '0;
               case (req_mode)
                  MODE_INSERT, MODE_DEL_VALUE: state_in = S_SCAN_RD;
                  MODE_DEL_POS: begin
                     if (req_position == '0 ||
                         CMP_W'(req_position) > CMP_W'(count_ff)) begin
                        strobe_in    = 1'b1;
                        status_in    = ST_BADPOS;
                        rsp_count_in = COUNT_W'(count_ff);
                     end else begin
                        ptr_in   = CNT_W'(req_position - 1'b1);
                        state_in = S_DOWN_RD;
                     end
                  end
                  default: begin
                     strobe_in    = 1'b1;
                     status_in    = ST_DONE;
                     rsp_count_in = COUNT_W'(count_ff);
                  end
               endcase
            end
         end

         // Walk the entries; end of the list closes the scan
         S_SCAN_RD: begin
            if (ptr_ff == count_ff) begin
               if (mode_ff == MODE_INSERT) begin
                  if (count_ff == CNT_W'(DEPTH)) begin
                     strobe_in    = 1'b1;
                     status_in    = ST_FULL;
                     rsp_count_in = COUNT_W'(count_ff);
                     state_in     = S_IDLE;
                  end else begin
                     ins_pos_in = ptr_ff;
                     ptr_in     = count_ff;
                     state_in   = S_UP_RD;
                  end
               end else begin
                  strobe_in    = 1'b1;
                  status_in    = ST_MISSING;
                  rsp_count_in = COUNT_W'(count_ff);
                  state_in     = S_IDLE;
               end
            end else begin
               state_in = S_SCAN_CMP;
            end
         end

         S_SCAN_CMP: begin
            if (mode_ff == MODE_INSERT) begin
               if (cmp.less) begin
                  ptr_in   = ptr_ff + 1'b1;
                  state_in = S_SCAN_RD;
               end else if (cmp.equal) begin
                  strobe_in    = 1'b1;
                  status_in    = ST_DUP;
                  rsp_count_in = COUNT_W'(count_ff);
                  state_in     = S_IDLE;
               end else if (count_ff == CNT_W'(DEPTH)) begin
                  strobe_in    = 1'b1;
                  status_in    = ST_FULL;
                  rsp_count_in = COUNT_W'(count_ff);
                  state_in     = S_IDLE;
               end else begin
                  ins_pos_in = ptr_ff;
                  ptr_in     = count_ff;
                  state_in   = S_UP_RD;
               end
            end else begin
               if (cmp.equal) begin
                  state_in = S_DOWN_RD;
               end else begin
                  ptr_in   = ptr_ff + 1'b1;
                  state_in = S_SCAN_RD;
               end
            end
         end

         // Open a gap: move entries up one place, then drop the key in
         S_UP_RD: begin
            if (ptr_ff == ins_pos_ff) begin
               count_in     = count_ff + 1'b1;
               strobe_in    = 1'b1;
               status_in    = ST_DONE;
               rsp_count_in = COUNT_W'(count_ff + 1'b1);
               state_in     = S_IDLE;
            end else begin
               state_in = S_UP_WR;
            end
         end

         S_UP_WR: begin
            ptr_in   = ptr_ff - 1'b1;
            state_in = S_UP_RD;
         end

         // Close a gap: move later entries down one place
         S_DOWN_RD: begin
            if (ptr_ff + 1'b1 >= count_ff) begin
               count_in     = count_ff - 1'b1;
               strobe_in    = 1'b1;
               status_in    = ST_DONE;
               rsp_count_in = COUNT_W'(count_ff - 1'b1);
               state_in     = S_IDLE;
            end else begin
               state_in = S_DOWN_WR;
            end
         end

         S_DOWN_WR: begin
            ptr_in   = ptr_ff + 1'b1;
            state_in = S_DOWN_RD;
         end

         default: state_in = S_IDLE;
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
         signed_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
         if (csr_valid && csr_ready) begin
            signed_ff <= csr_compare_signed;
         end
      end
      ptr_ff       <= ptr_in;
      ins_pos_ff   <= ins_pos_in;
      mode_ff      <= mode_in;
      key_ff       <= key_in;
      status_ff    <= status_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign busy            = state_ff != S_IDLE;
   assign csr_ready       = 1'b1;
   assign rsp_strobe      = strobe_ff;
   assign rsp_status      = status_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule
